// ===== rtl/urm_pkg.sv =====
// shared types and constants for the ultrasonic range meter
// no dependencies
`default_nettype none

package urm_pkg;

  localparam int CNT_W  = 16;
  localparam int CMP_W  = (CNT_W > 16) ? CNT_W : 16;
  localparam int FRAC_W = 16;
  localparam int DIST_W = 12;
  localparam int ACC_W  = ((CNT_W + 17) > (FRAC_W + DIST_W + 1)) ?
                          (CNT_W + 17) : (FRAC_W + DIST_W + 1);
  localparam int HI_W   = ACC_W - FRAC_W;
  localparam int DIST_MAX = 4095;

  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  localparam logic [IDX_W-1:0] REG_TIMEOUT = 3'd0;
  localparam logic [IDX_W-1:0] REG_TRIGGER = 3'd1;
  localparam logic [IDX_W-1:0] REG_SETTLE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCALE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET  = 3'd4;

  localparam logic [15:0] TIMEOUT_RST = 16'd30000;
  localparam logic [7:0]  TRIGGER_RST = 8'd10;
  localparam logic [7:0]  SETTLE_RST  = 8'd2;
  localparam logic [15:0] SCALE_RST   = 16'd2486;
  localparam logic [19:0] OFFSET_RST  = 20'd163840;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SETTLE = 5'b00010,
    PH_TRIG   = 5'b00100,
    PH_RISE   = 5'b01000,
    PH_FALL   = 5'b10000
  } phase_t;

endpackage

`default_nettype wire

// ===== rtl/ultrasonic_range_meter.sv =====
// trigger and echo ranging sequencer with apb register port
// depends on urm_pkg
`default_nettype none

// channel  | handshake              | payload
// item     | item_valid, item_ready | kind, echo
// result   | res_valid, res_ready   | trigger, busy_res, done_res, timed_out, range_cm
// config   | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// one word in, one word out; each accepted word is registered in the input stage, then in the result register
// a new word is taken every cycle while the result is not stalled; the per-word state update and the
// width-to-centimeter multiply sit between the input stage and the result register
// rst is synchronous; it restores config, handshake and state registers to their defaults, not payload
// a stalled result holds the input stage, which then holds item_ready low

module ultrasonic_range_meter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        kind,
  input  logic                        echo,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic                        trigger,
  output logic                        busy_res,
  output logic                        done_res,
  output logic                        timed_out,
  output logic [urm_pkg::DIST_W-1:0]  range_cm,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [urm_pkg::ADDR_W-1:0]  paddr,
  input  logic [urm_pkg::DATA_W-1:0]  pwdata,
  output logic [urm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import urm_pkg::*;

  logic [15:0] timeout_us;
  logic [7:0]  trigger_us;
  logic [7:0]  settle_us;
  logic [15:0] scale_q16;
  logic [19:0] offset_q16;

  logic             s_valid;
  logic             s_kind;
  logic             s_echo;
  logic             advance;

  phase_t           phase, phase_next;
  cnt_t             phase_ticks, ticks_next;
  cnt_t             echo_width, width_next;
  logic [DIST_W-1:0] last_distance, dist_next;
  logic             trig_level, trig_next;
  logic             done_next, tmo_next;

  cnt_t             ticks_inc, width_inc;
  logic             ticks_exp, width_exp;
  logic [ACC_W-1:0] acc;
  logic [HI_W-1:0]  cm_hi;
  logic [DIST_W-1:0] cm;

  logic             wr;
  logic [IDX_W-1:0] idx;

  // config port
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= TIMEOUT_RST;
      trigger_us <= TRIGGER_RST;
      settle_us  <= SETTLE_RST;
      scale_q16  <= SCALE_RST;
      offset_q16 <= OFFSET_RST;
    end else if (wr) begin
      case (idx)
        REG_TIMEOUT: timeout_us <= pwdata[15:0];
        REG_TRIGGER: trigger_us <= pwdata[7:0];
        REG_SETTLE:  settle_us  <= pwdata[7:0];
        REG_SCALE:   scale_q16  <= pwdata[15:0];
        REG_OFFSET:  offset_q16 <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIMEOUT: prdata = DATA_W'(timeout_us);
      REG_TRIGGER: prdata = DATA_W'(trigger_us);
      REG_SETTLE:  prdata = DATA_W'(settle_us);
      REG_SCALE:   prdata = DATA_W'(scale_q16);
      REG_OFFSET:  prdata = DATA_W'(offset_q16);
      default:     prdata = '0;
    endcase
  end

  // input stage and result register handshake
  assign advance    = s_valid && (!res_valid || res_ready);
  assign item_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (item_ready) begin
      s_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s_kind <= kind;
      s_echo <= echo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // saturating counters and timeout checks
  assign ticks_inc = (phase_ticks == CNT_MAX) ? CNT_MAX : phase_ticks + cnt_t'(1);
  assign width_inc = (echo_width == CNT_MAX) ? CNT_MAX : echo_width + cnt_t'(1);
  assign ticks_exp = (CMP_W'(ticks_inc) > CMP_W'(timeout_us)) || (ticks_inc == CNT_MAX);
  assign width_exp = (CMP_W'(width_inc) > CMP_W'(timeout_us)) || (width_inc == CNT_MAX);

  // width to centimeters
  assign acc   = ACC_W'(width_inc) * ACC_W'(scale_q16) + ACC_W'(offset_q16);
  assign cm_hi = acc[ACC_W-1:FRAC_W];
  assign cm    = (cm_hi > HI_W'(DIST_MAX)) ? DIST_W'(DIST_MAX) : cm_hi[DIST_W-1:0];

  always_comb begin
    phase_next = phase;
    ticks_next = phase_ticks;
    width_next = echo_width;
    dist_next  = last_distance;
    trig_next  = trig_level;
    done_next  = 1'b0;
    tmo_next   = 1'b0;
    if (s_kind) begin
      if (phase == PH_IDLE) begin
        ticks_next = '0;
        width_next = '0;
        if (settle_us == 8'd0) begin
          phase_next = PH_TRIG;
          trig_next  = 1'b1;
        end else begin
          phase_next = PH_SETTLE;
          trig_next  = 1'b0;
        end
      end
    end else begin
      case (phase)
        PH_IDLE: ;
        PH_SETTLE: begin
          ticks_next = ticks_inc;
          if (CMP_W'(ticks_inc) >= CMP_W'(settle_us)) begin
            phase_next = PH_TRIG;
            ticks_next = '0;
            trig_next  = 1'b1;
          end
        end
        PH_TRIG: begin
          ticks_next = ticks_inc;
          if (CMP_W'(ticks_inc) >= CMP_W'(trigger_us)) begin
            phase_next = PH_RISE;
            ticks_next = '0;
            trig_next  = 1'b0;
          end
        end
        PH_RISE: begin
          if (s_echo) begin
            phase_next = PH_FALL;
            width_next = '0;
          end else begin
            ticks_next = ticks_inc;
            if (ticks_exp) begin
              phase_next = PH_IDLE;
              done_next  = 1'b1;
              tmo_next   = 1'b1;
            end
          end
        end
        PH_FALL: begin
          width_next = width_inc;
          if (!s_echo) begin
            dist_next  = cm;
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end else if (width_exp) begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
            tmo_next   = 1'b1;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_ticks   <= '0;
      echo_width    <= '0;
      last_distance <= '0;
      trig_level    <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      phase_ticks   <= ticks_next;
      echo_width    <= width_next;
      last_distance <= dist_next;
      trig_level    <= trig_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trigger   <= trig_next;
      busy_res  <= (phase_next != PH_IDLE);
      done_res  <= done_next;
      timed_out <= tmo_next;
      range_cm  <= dist_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/urm_checker.sv =====
// port-level checks for the ultrasonic range meter, bound to the top level
// depends on urm_pkg
`default_nettype none

module urm_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_valid,
  input  logic                        res_ready,
  input  logic                        trigger,
  input  logic                        busy_res,
  input  logic                        done_res,
  input  logic                        timed_out,
  input  logic [urm_pkg::DIST_W-1:0]  range_cm
);
  import urm_pkg::*;

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(range_cm) && $stable(done_res))
    else $error("result word changed while stalled");

  // a finished measurement leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  // timeout only comes with done
  a_tmo_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && timed_out |-> done_res)
    else $error("timeout without done");

  // trigger is only driven during a measurement
  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && trigger |-> busy_res)
    else $error("trigger high while idle");

endmodule

bind ultrasonic_range_meter urm_checker u_urm_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .trigger   (trigger),
  .busy_res  (busy_res),
  .done_res  (done_res),
  .timed_out (timed_out),
  .range_cm  (range_cm)
);

`default_nettype wire
